/* design/two_level_page_table_walker_core_assert.svh */
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define PTW_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PTW_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PTW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ptw_pkg.sv */
`default_nettype none

package ptw_pkg;

   localparam int IN_DEPTH_DEFAULT  = 2;
   localparam int OUT_DEPTH_DEFAULT = 2;

   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] REG_MMU_ENABLE      = 3'd0;
   localparam logic [2:0] REG_ALIGN_CHECK     = 3'd1;
   localparam logic [2:0] REG_SYSTEM_BIT      = 3'd2;
   localparam logic [2:0] REG_ROM_BIT         = 3'd3;
   localparam logic [2:0] REG_TABLE_BASE_LOW  = 3'd4;
   localparam logic [2:0] REG_TABLE_BASE_HIGH = 3'd5;
   localparam logic [2:0] REG_SPLIT_BITS      = 3'd6;
   localparam logic [2:0] REG_CONTEXT_PID     = 3'd7;

   localparam logic ACTION_REQUEST    = 1'b0;
   localparam logic ACTION_DESCRIPTOR = 1'b1;

   localparam logic KIND_DESC_READ = 1'b0;
   localparam logic KIND_FINAL     = 1'b1;

   localparam logic [1:0] SIZE_BYTE     = 2'd0;
   localparam logic [1:0] SIZE_HALFWORD = 2'd1;
   localparam logic [1:0] SIZE_WORD     = 2'd2;
   localparam logic [1:0] SIZE_FETCH    = 2'd3;

   localparam logic [1:0] DESC_FAULT   = 2'd0;
   localparam logic [1:0] DESC_COARSE  = 2'd1;
   localparam logic [1:0] DESC_SECTION = 2'd2;
   localparam logic [1:0] DESC_LARGE   = 2'd1;

   localparam logic [2:0] FAULT_NONE      = 3'd0;
   localparam logic [2:0] FAULT_ALIGN     = 3'd1;
   localparam logic [2:0] FAULT_SECT_XLAT = 3'd2;
   localparam logic [2:0] FAULT_PAGE_XLAT = 3'd3;
   localparam logic [2:0] FAULT_SECT_PERM = 3'd4;
   localparam logic [2:0] FAULT_PAGE_PERM = 3'd5;

   localparam logic [1:0] AP_CONTROL = 2'd0;
   localparam logic [1:0] AP_PRIV    = 2'd1;
   localparam logic [1:0] AP_USER_RO = 2'd2;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_L1   = 2'd1,
      PHASE_L2   = 2'd2
   } phase_type;

   typedef struct packed {
      logic        mmu_enable;
      logic        align_check;
      logic        system_bit;
      logic        rom_bit;
      logic [31:0] table_base_low;
      logic [31:0] table_base_high;
      logic [2:0]  split_bits;
      logic [6:0]  context_pid;
   } cfg_type;

   typedef struct packed {
      logic        action;
      logic        start_walk;
      logic        kind;
      logic [2:0]  fault_code;
      logic [31:0] address;
      logic [31:0] vaddr;
      logic [1:0]  access_size;
      logic        is_write;
      logic        is_user;
   } entry_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [2:0]  fault_code;
   } result_type;

endpackage

`default_nettype wire

/* design/ptw_fifo.sv */
`default_nettype none
`include "two_level_page_table_walker_core_assert.svh"

module ptw_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = ptw_pkg::IN_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_wr) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `PTW_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "fifo overfilled")
   `PTW_ASSERT_NEXT(a_write_fills, clock, reset, do_wr && !do_rd, !empty, "written item lost")
   `PTW_ASSERT_NEXT(a_last_read, clock, reset, do_rd && !do_wr && count_ff == CNT_W'(1), empty,
      "fifo not empty after last read")

endmodule

`default_nettype wire

/* design/ptw_front.sv */
`default_nettype none

module ptw_front (
   input  wire ptw_pkg::cfg_type   cfg,
   input  wire logic               action,
   input  wire logic [31:0]        vaddr,
   input  wire logic [1:0]         access_size,
   input  wire logic               is_write,
   input  wire logic               is_user,
   input  wire logic [31:0]        descriptor,
   output ptw_pkg::entry_type      entry
);

   logic [31:0] va_pid, va_walk, top_mask, base_mask, va_index, l1_addr;
   logic [4:0]  low_shift;
   logic        misaligned, upper_table;

   always_comb begin
      va_pid = vaddr;
      if (vaddr[31:25] == 7'd0) begin
         va_pid[31:25] = cfg.context_pid;
      end

      unique case (access_size)
         ptw_pkg::SIZE_BYTE:     misaligned = 1'b0;
         ptw_pkg::SIZE_HALFWORD: misaligned = va_pid[0];
         default:                misaligned = (va_pid[1:0] != 2'd0);
      endcase

      va_walk = va_pid;
      if (access_size == ptw_pkg::SIZE_FETCH ||
          (access_size == ptw_pkg::SIZE_WORD && is_write)) begin
         va_walk[1:0] = 2'd0;
      end

      top_mask    = ~(32'hFFFF_FFFF >> cfg.split_bits);
      upper_table = (cfg.split_bits != 3'd0) && ((va_walk & top_mask) != 32'd0);
      low_shift   = 5'd14 - {2'd0, cfg.split_bits};
      base_mask   = 32'hFFFF_FFFF << low_shift;
      va_index    = va_walk >> 18;
      if (upper_table) begin
         l1_addr = (cfg.table_base_high & 32'hFFFF_C000) | va_index;
      end else begin
         l1_addr = (cfg.table_base_low & base_mask) | (va_index & ~base_mask);
      end
      l1_addr[1:0] = 2'd0;
   end

   always_comb begin
      entry.action      = action;
      entry.start_walk  = 1'b0;
      entry.kind        = ptw_pkg::KIND_FINAL;
      entry.fault_code  = ptw_pkg::FAULT_NONE;
      entry.address     = descriptor;
      entry.vaddr       = va_walk;
      entry.access_size = access_size;
      entry.is_write    = is_write;
      entry.is_user     = is_user;
      if (action == ptw_pkg::ACTION_REQUEST) begin
         if (!cfg.mmu_enable) begin
            entry.address = va_pid;
         end else if (cfg.align_check && misaligned) begin
            entry.address    = 32'd0;
            entry.fault_code = ptw_pkg::FAULT_ALIGN;
         end else begin
            entry.start_walk = 1'b1;
            entry.kind       = ptw_pkg::KIND_DESC_READ;
            entry.address    = l1_addr;
         end
      end
   end

endmodule

`default_nettype wire

/* design/ptw_back.sv */
`default_nettype none
`include "two_level_page_table_walker_core_assert.svh"

module ptw_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ptw_pkg::cfg_type    cfg,
   input  wire ptw_pkg::entry_type  entry,
   input  wire logic                entry_empty,
   output logic                     entry_pop,
   input  wire logic                result_full,
   output logic                     result_push,
   output ptw_pkg::result_type      result
);

   ptw_pkg::phase_type phase_ff, phase_in;
   logic [31:0] held_vaddr_ff;
   logic [1:0]  held_size_ff;
   logic        held_write_ff;
   logic        held_user_ff;

   logic        take, is_read, ap_ok, result_valid;
   logic [1:0]  ap;
   logic [31:0] desc;

   assign take      = !entry_empty && !result_full;
   assign entry_pop = take;
   assign desc      = entry.address;
   assign is_read   = !held_write_ff || (held_size_ff == ptw_pkg::SIZE_FETCH);

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         if (entry.action == ptw_pkg::ACTION_REQUEST) begin
            phase_in = entry.start_walk ? ptw_pkg::PHASE_L1 : ptw_pkg::PHASE_IDLE;
         end else begin
            unique case (phase_ff)
               ptw_pkg::PHASE_L1:
                  phase_in = (desc[1:0] == ptw_pkg::DESC_COARSE) ?
                             ptw_pkg::PHASE_L2 : ptw_pkg::PHASE_IDLE;
               ptw_pkg::PHASE_L2: phase_in = ptw_pkg::PHASE_IDLE;
               default:           phase_in = ptw_pkg::PHASE_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      ap = (phase_ff == ptw_pkg::PHASE_L1) ? desc[11:10] : desc[5:4];
      unique case (ap)
         ptw_pkg::AP_CONTROL:
            ap_ok = is_read && ((cfg.system_bit && !held_user_ff) || cfg.rom_bit);
         ptw_pkg::AP_PRIV:    ap_ok = !held_user_ff;
         ptw_pkg::AP_USER_RO: ap_ok = is_read || !held_user_ff;
         default:             ap_ok = 1'b1;
      endcase

      result_valid      = 1'b0;
      result.kind       = ptw_pkg::KIND_FINAL;
      result.address    = 32'd0;
      result.fault_code = ptw_pkg::FAULT_NONE;

      if (entry.action == ptw_pkg::ACTION_REQUEST) begin
         result_valid      = 1'b1;
         result.kind       = entry.kind;
         result.address    = entry.address;
         result.fault_code = entry.fault_code;
      end else begin
         unique case (phase_ff)
            ptw_pkg::PHASE_L1: begin
               result_valid = 1'b1;
               if (desc[1:0] == ptw_pkg::DESC_COARSE) begin
                  result.kind    = ptw_pkg::KIND_DESC_READ;
                  result.address = {desc[31:10], held_vaddr_ff[19:12], 2'b00};
               end else if (desc[1:0] == ptw_pkg::DESC_SECTION) begin
                  if (!ap_ok) begin
                     result.fault_code = ptw_pkg::FAULT_SECT_PERM;
                  end else if (desc[18]) begin
                     result.address = {desc[31:24], held_vaddr_ff[23:0]};
                  end else begin
                     result.address = {desc[31:20], held_vaddr_ff[19:0]};
                  end
               end else begin
                  result.fault_code = ptw_pkg::FAULT_SECT_XLAT;
               end
            end
            ptw_pkg::PHASE_L2: begin
               result_valid = 1'b1;
               if (desc[1:0] == ptw_pkg::DESC_FAULT) begin
                  result.fault_code = ptw_pkg::FAULT_PAGE_XLAT;
               end else if (!ap_ok) begin
                  result.fault_code = ptw_pkg::FAULT_PAGE_PERM;
               end else if (desc[1:0] == ptw_pkg::DESC_LARGE) begin
                  result.address = {desc[31:16], held_vaddr_ff[15:0]};
               end else begin
                  result.address = {desc[31:12], held_vaddr_ff[11:0]};
               end
            end
            default: result_valid = 1'b0;
         endcase
      end

      result_push = take && result_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ptw_pkg::PHASE_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && entry.action == ptw_pkg::ACTION_REQUEST) begin
         held_vaddr_ff <= entry.vaddr;
         held_size_ff  <= entry.access_size;
         held_write_ff <= entry.is_write;
         held_user_ff  <= entry.is_user;
      end
   end

   `PTW_ASSERT_NEXT(a_no_skip_l1, clock, reset, phase_ff == ptw_pkg::PHASE_IDLE,
      phase_ff != ptw_pkg::PHASE_L2, "second level entered without first")
   `PTW_ASSERT_IMPLIES(a_fault_zero_addr, clock, reset,
      result_push && result.fault_code != ptw_pkg::FAULT_NONE, result.address == 32'd0,
      "faulting result carries an address")
   `PTW_ASSERT_IMPLIES(a_read_no_fault, clock, reset,
      result_push && result.kind == ptw_pkg::KIND_DESC_READ,
      result.fault_code == ptw_pkg::FAULT_NONE && phase_in != ptw_pkg::PHASE_IDLE,
      "descriptor read without a walk")

endmodule

`default_nettype wire

/* design/two_level_page_table_walker_core.sv */
`default_nettype none

// Short-descriptor two-level page table walker without a TLB. Requests and
// returned descriptors enter on the req_ queue port; each produces at most
// one item on the rsp_ queue port: a descriptor read address (rsp_kind 0) to
// be fetched and answered with a descriptor item, or a final physical
// address or fault (rsp_kind 1). One item is accepted per cycle while the
// result queue has room; the back end works on the head of the input queue
// and writes its result into the result queue at the edge that takes the
// item. A descriptor arriving with no walk in progress gives no result;
// a new request abandons any walk in progress.
// Registers lie at byte addresses 4*i on the csr_ port; the user must write
// them only while the walker is idle, which the block does not enforce.

module two_level_page_table_walker_core #(
   parameter int IN_DEPTH  = ptw_pkg::IN_DEPTH_DEFAULT,
   parameter int OUT_DEPTH = ptw_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_action,
   input  wire logic [31:0]                    req_vaddr,
   input  wire logic [1:0]                     req_access_size,
   input  wire logic                           req_is_write,
   input  wire logic                           req_is_user,
   input  wire logic [31:0]                    req_descriptor,

   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic                                rsp_kind,
   output logic [31:0]                         rsp_address,
   output logic [2:0]                          rsp_fault_code,

   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ptw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int ENTRY_W  = $bits(ptw_pkg::entry_type);
   localparam int RESULT_W = $bits(ptw_pkg::result_type);

   ptw_pkg::cfg_type    cfg_ff, cfg_in;
   ptw_pkg::entry_type  front_entry, back_entry;
   ptw_pkg::result_type back_result, head_result;
   logic [ENTRY_W-1:0]  back_entry_bits;
   logic [RESULT_W-1:0] head_result_bits;
   logic [2:0]          csr_index;
   logic                csr_write;
   logic                entry_empty, entry_pop, result_full, result_push;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            ptw_pkg::REG_MMU_ENABLE:      cfg_in.mmu_enable      = csr_pwdata[0];
            ptw_pkg::REG_ALIGN_CHECK:     cfg_in.align_check     = csr_pwdata[0];
            ptw_pkg::REG_SYSTEM_BIT:      cfg_in.system_bit      = csr_pwdata[0];
            ptw_pkg::REG_ROM_BIT:         cfg_in.rom_bit         = csr_pwdata[0];
            ptw_pkg::REG_TABLE_BASE_LOW:  cfg_in.table_base_low  = csr_pwdata;
            ptw_pkg::REG_TABLE_BASE_HIGH: cfg_in.table_base_high = csr_pwdata;
            ptw_pkg::REG_SPLIT_BITS:      cfg_in.split_bits      = csr_pwdata[2:0];
            ptw_pkg::REG_CONTEXT_PID:     cfg_in.context_pid     = csr_pwdata[6:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         ptw_pkg::REG_MMU_ENABLE:      csr_prdata = {31'd0, cfg_ff.mmu_enable};
         ptw_pkg::REG_ALIGN_CHECK:     csr_prdata = {31'd0, cfg_ff.align_check};
         ptw_pkg::REG_SYSTEM_BIT:      csr_prdata = {31'd0, cfg_ff.system_bit};
         ptw_pkg::REG_ROM_BIT:         csr_prdata = {31'd0, cfg_ff.rom_bit};
         ptw_pkg::REG_TABLE_BASE_LOW:  csr_prdata = cfg_ff.table_base_low;
         ptw_pkg::REG_TABLE_BASE_HIGH: csr_prdata = cfg_ff.table_base_high;
         ptw_pkg::REG_SPLIT_BITS:      csr_prdata = {29'd0, cfg_ff.split_bits};
         ptw_pkg::REG_CONTEXT_PID:     csr_prdata = {25'd0, cfg_ff.context_pid};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptw_front u_front (
      .cfg         (cfg_ff),
      .action      (req_action),
      .vaddr       (req_vaddr),
      .access_size (req_access_size),
      .is_write    (req_is_write),
      .is_user     (req_is_user),
      .descriptor  (req_descriptor),
      .entry       (front_entry)
   );

   ptw_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (IN_DEPTH)
   ) u_entry_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_push),
      .wr_data (front_entry),
      .full    (req_full),
      .rd_en   (entry_pop),
      .rd_data (back_entry_bits),
      .empty   (entry_empty)
   );

   assign back_entry = ptw_pkg::entry_type'(back_entry_bits);

   ptw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .entry       (back_entry),
      .entry_empty (entry_empty),
      .entry_pop   (entry_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (back_result)
   );

   ptw_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (OUT_DEPTH)
   ) u_result_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (result_push),
      .wr_data (back_result),
      .full    (result_full),
      .rd_en   (rsp_pop),
      .rd_data (head_result_bits),
      .empty   (rsp_empty)
   );

   assign head_result    = ptw_pkg::result_type'(head_result_bits);
   assign rsp_kind       = head_result.kind;
   assign rsp_address    = head_result.address;
   assign rsp_fault_code = head_result.fault_code;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;

   localparam int STALL_PCT      = 14;
   localparam int SETTLE_CYCLES  = 6;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_RESULTS  = 135;

   localparam logic [1:0] DESC_RESERVED = 2'd3;

   typedef struct {
      logic        action;
      logic [31:0] vaddr;
      logic [1:0]  size;
      logic        wr;
      logic        usr;
      logic [31:0] desc;
   } walk_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_action = ptw_pkg::ACTION_REQUEST;
   logic [31:0] req_vaddr = '0;
   logic [1:0]  req_access_size = ptw_pkg::SIZE_BYTE;
   logic        req_is_write = 1'b0;
   logic        req_is_user = 1'b0;
   logic [31:0] req_descriptor = '0;

   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_kind;
   logic [31:0] rsp_address;
   logic [2:0]  rsp_fault_code;

   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [ptw_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]                    csr_pwdata = '0;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   ptw_pkg::cfg_type   walk_cfg = '0;
   ptw_pkg::phase_type walk_phase = ptw_pkg::PHASE_IDLE;
   logic [31:0]        walk_va = '0;
   logic [1:0]         walk_size = ptw_pkg::SIZE_BYTE;
   logic               walk_write = 1'b0;
   logic               walk_user = 1'b0;

   ptw_pkg::result_type walk_results_q[$];
   int                  predicted_count = 0;
   int                  mismatches = 0;
   int                  quiet_cycles = 0;
   bit                  no_gaps = 1'b0;

   two_level_page_table_walker_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_action      (req_action),
      .req_vaddr       (req_vaddr),
      .req_access_size (req_access_size),
      .req_is_write    (req_is_write),
      .req_is_user     (req_is_user),
      .req_descriptor  (req_descriptor),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_address     (rsp_address),
      .rsp_fault_code  (rsp_fault_code),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic bit ap_allows(input logic [1:0] ap);
      bit rd;
      rd = !walk_write || walk_size == ptw_pkg::SIZE_FETCH;
      case (ap)
         ptw_pkg::AP_CONTROL:
            return rd && ((walk_cfg.system_bit && !walk_user) || walk_cfg.rom_bit);
         ptw_pkg::AP_PRIV:    return !walk_user;
         ptw_pkg::AP_USER_RO: return rd || !walk_user;
         default:             return 1'b1;
      endcase
   endfunction

   function automatic logic [31:0] l1_addr(input logic [31:0] va);
      logic [31:0] base;
      logic [31:0] shifted;
      logic [31:0] a;
      int          n;
      n = walk_cfg.split_bits;
      if (n != 0 && (va >> (32 - n)) != 0) begin
         a = (walk_cfg.table_base_high & 32'hFFFF_C000) | (va >> 18);
      end else begin
         base = (walk_cfg.table_base_low >> (14 - n)) << (14 - n);
         shifted = va << n;
         a = base | (shifted >> (18 + n));
      end
      a[1:0] = 2'b00;
      return a;
   endfunction

   function automatic bit walk_model(input walk_item_type it, output ptw_pkg::result_type r);
      logic [31:0] va;
      logic [31:0] pa;
      logic        mis;
      r.kind = ptw_pkg::KIND_FINAL;
      r.address = '0;
      r.fault_code = ptw_pkg::FAULT_NONE;
      if (it.action == ptw_pkg::ACTION_REQUEST) begin
         va = it.vaddr;
         walk_size = it.size;
         walk_write = it.wr;
         walk_user = it.usr;
         walk_phase = ptw_pkg::PHASE_IDLE;
         if (va[31:25] == 7'd0) begin
            va[31:25] = walk_cfg.context_pid;
         end
         if (!walk_cfg.mmu_enable) begin
            r.address = va;
            return 1'b1;
         end
         if (walk_cfg.align_check) begin
            if (walk_size == ptw_pkg::SIZE_HALFWORD) begin
               mis = va[0];
            end else begin
               mis = (walk_size == ptw_pkg::SIZE_WORD || walk_size == ptw_pkg::SIZE_FETCH) &&
                     va[1:0] != 2'b00;
            end
            if (mis) begin
               r.fault_code = ptw_pkg::FAULT_ALIGN;
               return 1'b1;
            end
         end
         if (walk_size == ptw_pkg::SIZE_FETCH ||
             (walk_size == ptw_pkg::SIZE_WORD && walk_write)) begin
            va[1:0] = 2'b00;
         end
         walk_va = va;
         walk_phase = ptw_pkg::PHASE_L1;
         r.kind = ptw_pkg::KIND_DESC_READ;
         r.address = l1_addr(va);
         return 1'b1;
      end
      case (walk_phase)
         ptw_pkg::PHASE_L1: begin
            case (it.desc[1:0])
               ptw_pkg::DESC_COARSE: begin
                  walk_phase = ptw_pkg::PHASE_L2;
                  r.kind = ptw_pkg::KIND_DESC_READ;
                  r.address = {it.desc[31:10], walk_va[19:12], 2'b00};
               end
               ptw_pkg::DESC_SECTION: begin
                  walk_phase = ptw_pkg::PHASE_IDLE;
                  if (it.desc[18]) begin
                     pa = {it.desc[31:24], walk_va[23:0]};
                  end else begin
                     pa = {it.desc[31:20], walk_va[19:0]};
                  end
                  if (ap_allows(it.desc[11:10])) begin
                     r.address = pa;
                  end else begin
                     r.fault_code = ptw_pkg::FAULT_SECT_PERM;
                  end
               end
               default: begin
                  walk_phase = ptw_pkg::PHASE_IDLE;
                  r.fault_code = ptw_pkg::FAULT_SECT_XLAT;
               end
            endcase
            return 1'b1;
         end
         ptw_pkg::PHASE_L2: begin
            walk_phase = ptw_pkg::PHASE_IDLE;
            if (it.desc[1:0] == ptw_pkg::DESC_FAULT) begin
               r.fault_code = ptw_pkg::FAULT_PAGE_XLAT;
               return 1'b1;
            end
            if (it.desc[1:0] == ptw_pkg::DESC_LARGE) begin
               pa = {it.desc[31:16], walk_va[15:0]};
            end else begin
               pa = {it.desc[31:12], walk_va[11:0]};
            end
            if (ap_allows(it.desc[5:4])) begin
               r.address = pa;
            end else begin
               r.fault_code = ptw_pkg::FAULT_PAGE_PERM;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic walk_item_type random_request();
      walk_item_type it;
      it.action = ptw_pkg::ACTION_REQUEST;
      it.vaddr = $urandom;
      if ($urandom_range(3) == 0) begin
         it.vaddr[31:25] = 7'd0;
      end
      it.size = 2'($urandom_range(3));
      it.wr = 1'($urandom_range(1));
      it.usr = 1'($urandom_range(1));
      it.desc = $urandom;
      return it;
   endfunction

   function automatic walk_item_type random_descriptor(input logic [1:0] kind_bits);
      walk_item_type it;
      it = random_request();
      it.action = ptw_pkg::ACTION_DESCRIPTOR;
      it.desc[1:0] = kind_bits;
      return it;
   endfunction

   function automatic walk_item_type req_item(input logic [31:0] va, input logic [1:0] sz,
                                              input logic wr, input logic usr);
      walk_item_type it;
      it = random_request();
      it.vaddr = va;
      it.size = sz;
      it.wr = wr;
      it.usr = usr;
      return it;
   endfunction

   function automatic walk_item_type desc_item(input logic [31:0] d);
      walk_item_type it;
      it = random_descriptor(d[1:0]);
      it.desc = d;
      return it;
   endfunction

   function automatic logic [1:0] pick_l1_type();
      int roll;
      roll = $urandom_range(9);
      if (roll < 4) return ptw_pkg::DESC_SECTION;
      if (roll < 8) return ptw_pkg::DESC_COARSE;
      if (roll == 8) return ptw_pkg::DESC_FAULT;
      return DESC_RESERVED;
   endfunction

   function automatic ptw_pkg::cfg_type random_cfg();
      ptw_pkg::cfg_type c;
      c.mmu_enable = 1'b1;
      c.align_check = 1'($urandom_range(1));
      c.system_bit = 1'($urandom_range(1));
      c.rom_bit = 1'($urandom_range(1));
      c.table_base_low = $urandom;
      c.table_base_high = $urandom;
      c.split_bits = 3'($urandom_range(7));
      c.context_pid = 7'($urandom_range(127));
      return c;
   endfunction

   function automatic void note_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %s: expected %h, got %h", what, want, got);
      end
   endfunction

   task automatic send_item(input walk_item_type it);
      ptw_pkg::result_type r;
      while (!no_gaps && $urandom_range(99) < STALL_PCT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_action <= it.action;
      req_vaddr <= it.vaddr;
      req_access_size <= it.size;
      req_is_write <= it.wr;
      req_is_user <= it.usr;
      req_descriptor <= it.desc;
      do @(posedge clock); while (req_full);
      if (walk_model(it, r)) begin
         walk_results_q.push_back(r);
         predicted_count++;
      end
   endtask

   task automatic drain_walker();
      req_push <= 1'b0;
      while (walk_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         ptw_pkg::REG_MMU_ENABLE:      walk_cfg.mmu_enable = val[0];
         ptw_pkg::REG_ALIGN_CHECK:     walk_cfg.align_check = val[0];
         ptw_pkg::REG_SYSTEM_BIT:      walk_cfg.system_bit = val[0];
         ptw_pkg::REG_ROM_BIT:         walk_cfg.rom_bit = val[0];
         ptw_pkg::REG_TABLE_BASE_LOW:  walk_cfg.table_base_low = val;
         ptw_pkg::REG_TABLE_BASE_HIGH: walk_cfg.table_base_high = val;
         ptw_pkg::REG_SPLIT_BITS:      walk_cfg.split_bits = val[2:0];
         default:                      walk_cfg.context_pid = val[6:0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input ptw_pkg::cfg_type c);
      csr_write(ptw_pkg::REG_MMU_ENABLE, 32'(c.mmu_enable));
      csr_write(ptw_pkg::REG_ALIGN_CHECK, 32'(c.align_check));
      csr_write(ptw_pkg::REG_SYSTEM_BIT, 32'(c.system_bit));
      csr_write(ptw_pkg::REG_ROM_BIT, 32'(c.rom_bit));
      csr_write(ptw_pkg::REG_TABLE_BASE_LOW, c.table_base_low);
      csr_write(ptw_pkg::REG_TABLE_BASE_HIGH, c.table_base_high);
      csr_write(ptw_pkg::REG_SPLIT_BITS, 32'(c.split_bits));
      csr_write(ptw_pkg::REG_CONTEXT_PID, 32'(c.context_pid));
   endtask

   task automatic test_bypass();
      drain_walker();
      set_config('{mmu_enable: 1'b0, align_check: 1'b1, system_bit: 1'b0, rom_bit: 1'b0,
                   table_base_low: 32'h0, table_base_high: 32'h0, split_bits: 3'd0,
                   context_pid: 7'd127});
      send_item(req_item(32'h0000_1234, ptw_pkg::SIZE_WORD, 1'b1, 1'b0));
      send_item(req_item(32'hFFFF_FFFF, ptw_pkg::SIZE_HALFWORD, 1'b0, 1'b1));
      send_item(req_item(32'h01FF_FFFF, ptw_pkg::SIZE_FETCH, 1'b0, 1'b0));
      send_item(desc_item(32'h0000_0C02));
   endtask

   task automatic test_alignment();
      drain_walker();
      set_config('{mmu_enable: 1'b1, align_check: 1'b1, system_bit: 1'b0, rom_bit: 1'b1,
                   table_base_low: 32'h0, table_base_high: 32'h0, split_bits: 3'd0,
                   context_pid: 7'd0});
      send_item(req_item(32'h1000_0001, ptw_pkg::SIZE_HALFWORD, 1'b0, 1'b0));
      send_item(req_item(32'h1000_0002, ptw_pkg::SIZE_WORD, 1'b1, 1'b0));
      send_item(req_item(32'h1000_0001, ptw_pkg::SIZE_FETCH, 1'b0, 1'b0));
      send_item(req_item(32'h1000_0003, ptw_pkg::SIZE_BYTE, 1'b1, 1'b1));
      send_item(req_item(32'h1000_0002, ptw_pkg::SIZE_HALFWORD, 1'b0, 1'b1));
      send_item(desc_item(32'h0000_0002));
   endtask

   task automatic test_first_level();
      drain_walker();
      set_config('{mmu_enable: 1'b1, align_check: 1'b0, system_bit: 1'b0, rom_bit: 1'b0,
                   table_base_low: 32'hFFFF_FFFF, table_base_high: 32'hFFFF_FFFF,
                   split_bits: 3'd7, context_pid: 7'd0});
      send_item(req_item(32'h0123_4567, ptw_pkg::SIZE_WORD, 1'b1, 1'b0));
      send_item(desc_item(32'hABC0_0C02));
      send_item(req_item(32'hFFFF_FFFE, ptw_pkg::SIZE_FETCH, 1'b1, 1'b1));
      send_item(desc_item(32'h5A04_0C02));
      send_item(req_item(32'h8000_0000, ptw_pkg::SIZE_BYTE, 1'b0, 1'b0));
      send_item(desc_item(32'hFFFF_FFF0));
      send_item(req_item(32'h0000_0001, ptw_pkg::SIZE_HALFWORD, 1'b0, 1'b1));
      send_item(desc_item(32'h0000_0003));
   endtask

   task automatic test_second_level();
      drain_walker();
      set_config('{mmu_enable: 1'b1, align_check: 1'b1, system_bit: 1'b1, rom_bit: 1'b0,
                   table_base_low: 32'h0, table_base_high: 32'h1234_5678,
                   split_bits: 3'd1, context_pid: 7'h55});
      send_item(req_item(32'h0000_F000, ptw_pkg::SIZE_WORD, 1'b0, 1'b0));
      send_item(desc_item(32'h8765_4401));
      send_item(desc_item(32'hFFFF_0031));
      send_item(req_item(32'hC000_0002, ptw_pkg::SIZE_HALFWORD, 1'b1, 1'b1));
      send_item(desc_item(32'h0000_0001));
      send_item(desc_item(32'h1234_5003));
      send_item(req_item(32'h4000_0000, ptw_pkg::SIZE_BYTE, 1'b0, 1'b1));
      send_item(desc_item(32'hFFFF_FFFD));
      send_item(desc_item(32'hFFFF_FFFC));
   endtask

   task automatic test_random_walks();
      ptw_pkg::cfg_type c;
      walk_item_type    it;
      int               target;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_walker();
         no_gaps = (phase == 5);
         case (phase)
            0: c = '0;
            1: c = '1;
            2: begin
               c = '0;
               c.mmu_enable = 1'b1;
            end
            default: c = random_cfg();
         endcase
         set_config(c);
         target = predicted_count + PHASE_RESULTS;
         while (predicted_count < target) begin
            if ($urandom_range(99) < 80) begin
               send_item(random_request());
               if (walk_phase == ptw_pkg::PHASE_L1 && $urandom_range(9) != 0) begin
                  send_item(random_descriptor(pick_l1_type()));
                  if (walk_phase == ptw_pkg::PHASE_L2) begin
                     send_item(random_descriptor(2'($urandom_range(3))));
                  end
               end
            end else begin
               it = random_request();
               it.action = 1'($urandom_range(1));
               send_item(it);
            end
         end
         while (walk_phase != ptw_pkg::PHASE_IDLE) begin
            send_item(random_descriptor(ptw_pkg::DESC_SECTION));
         end
      end
      no_gaps = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= no_gaps || ($urandom_range(99) >= STALL_PCT);
      end
   end

   always @(posedge clock) begin
      ptw_pkg::result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (walk_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected item: kind %0d address %h fault %0d",
                        rsp_kind, rsp_address, rsp_fault_code);
            end
         end else begin
            want = walk_results_q.pop_front();
            if (rsp_kind !== want.kind) begin
               note_mismatch("kind", 32'(want.kind), 32'(rsp_kind));
            end
            if (rsp_address !== want.address) begin
               note_mismatch("address", want.address, rsp_address);
            end
            if (rsp_fault_code !== want.fault_code) begin
               note_mismatch("fault_code", 32'(want.fault_code), 32'(rsp_fault_code));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("two_level_page_table_walker_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_bypass();
      test_alignment();
      test_first_level();
      test_second_level();
      test_random_walks();
      drain_walker();
      if (mismatches == 0 && walk_results_q.size() == 0) begin
         $display("two_level_page_table_walker_core test passed");
      end else begin
         $display("two_level_page_table_walker_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/ptw_pkg.sv
design/ptw_fifo.sv
design/ptw_front.sv
design/ptw_back.sv
design/two_level_page_table_walker_core.sv
tb/sv/tb.sv
